/* rtl/core/sxfb_pkg.sv */
`timescale 1ns / 1ps

package sxfb_pkg;

  // Default geometry of the display and the sprite, and the fade depth.
  localparam int SXFB_DISPLAY_WIDTH  = 64;
  localparam int SXFB_DISPLAY_HEIGHT = 32;
  localparam int SXFB_SPRITE_COLS    = 8;
  localparam int SXFB_FADE_BITS      = 4;

  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_SCAN  = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] x_coord;
    logic [7:0] y_coord;
    logic [3:0] sprite_row_index;
    logic [7:0] sprite_bits;
    logic       first_row;
    logic [4:0] scan_line;
  } sxfb_in_t;

  typedef struct packed {
    logic       collision;
    logic [5:0] pixel_column;
    logic       pixel_on;
    logic [3:0] fade_level;
    logic       last;
  } sxfb_out_t;

endpackage

/* rtl/core/sxfb_fade_unit.sv */
`timescale 1ns / 1ps

module sxfb_fade_unit import sxfb_pkg::*; #(
  parameter int ADDR_W    = 11,
  parameter int FADE_BITS = SXFB_FADE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [FADE_BITS-1:0] rd_level,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [FADE_BITS-1:0] wr_level,
  output logic                 busy
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [FADE_BITS-1:0] mem [DEPTH];
  logic [FADE_BITS-1:0] rd_level_r;
  logic [ADDR_W-1:0]    clr_cnt_r;
  logic                 busy_r;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [FADE_BITS-1:0] wdata;

  // After reset every level is swept to zero, one entry per cycle.
  always_comb begin
    we    = wr_en;
    waddr = wr_addr;
    wdata = wr_level;
    if (busy_r) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      busy_r    <= 1'b1;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == {ADDR_W{1'b1}}) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_level_r <= mem[rd_addr];
    end
  end

  assign rd_level = rd_level_r;
  assign busy     = busy_r;

endmodule

/* rtl/core/sprite_xor_frame_buffer_with_fade.sv */
`timescale 1ns / 1ps

// Monochrome frame buffer with sprite XOR drawing and a per-pixel fade level.
// Input channel: in_valid/in_stall carry one command request in in_data.
// Result channel: out_valid/out_stall carry one result in out_data, held in an
// output register so a new request is taken while a result still waits.
// cfg_wr_en/cfg_wr_data set the fade length, saturated at 2^FADE_BITS-2.
// A draw reads its row, XORs the sprite mask in and returns one collision
// result when the output register is free; the next request is taken once
// it is registered. A clear returns nothing. A scan request reads its row,
// then streams DISPLAY_WIDTH pixels one per cycle, unless out_stall holds the
// output, through the fade memory (read, update, write back); the first pixel
// passes the row load state, the fade memory read and the output register;
// the next request is taken once the last pixel is registered. The fade
// memory read-modify-write of one pixel per cycle sets that rate. After reset
// the fade memory is swept to zero, one entry per cycle, over all entries,
// 2^(ceil(log2(DISPLAY_HEIGHT))+ceil(log2(DISPLAY_WIDTH))), 2048 by default;
// in_stall stays high during the sweep while configuration writes still land.
// When out_stall is held, the scan pauses pixel by pixel and nothing is lost.
module sprite_xor_frame_buffer_with_fade import sxfb_pkg::*; #(
  parameter int DISPLAY_WIDTH  = SXFB_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = SXFB_DISPLAY_HEIGHT,
  parameter int SPRITE_COLS    = SXFB_SPRITE_COLS,
  parameter int FADE_BITS      = SXFB_FADE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  sxfb_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output sxfb_out_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  localparam int W      = DISPLAY_WIDTH;
  localparam int H      = DISPLAY_HEIGHT;
  localparam int SC     = SPRITE_COLS;
  localparam int COL_W  = $clog2(W);
  localparam int ROW_W  = $clog2(H);
  localparam int FA_W   = ROW_W + COL_W;
  localparam int CW     = (FADE_BITS > 4) ? FADE_BITS : 4;
  localparam int FADE_CAP = (1 << FADE_BITS) - 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_SCAN_LD,
    ST_SCAN
  } state_t;

  state_t                state_r, state_nxt;
  logic [FADE_BITS-1:0]  fade_frames_r, fade_frames_nxt;
  logic                  coll_r, coll_nxt;
  logic [H-1:0]          frame_valid_r, frame_valid_nxt;
  logic                  frame_rdv_r, frame_rdv_nxt;
  logic [W-1:0]          frame_rd_r;
  logic [W-1:0]          mask_r, mask_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic                  row_ok_r, row_ok_nxt;
  logic [W-1:0]          row_sr_r, row_sr_nxt;
  logic [COL_W:0]        rd_cnt_r, rd_cnt_nxt;
  logic                  p1_valid_r, p1_valid_nxt;
  logic [COL_W-1:0]      p1_col_r, p1_col_nxt;
  sxfb_out_t             out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [W-1:0]          frame_mem [H];
  logic                  fr_re, fr_we;
  logic [ROW_W-1:0]      fr_raddr;
  logic [W-1:0]          fr_wdata;

  logic                  fa_rd_en, fa_wr_en, fa_busy;
  logic [FA_W-1:0]       fa_rd_addr, fa_wr_addr;
  logic [FADE_BITS-1:0]  fa_rd_level, fa_wr_level;

  logic                  in_acc, out_free, issue, p1_adv, pix_on, last_pix;
  logic [8:0]            row_sum;
  logic [11:0]           x_mod;
  logic [SC-1:0]         spr;
  logic [W+SC-1:0]       spr_wide;
  logic [W-1:0]          old_row;
  logic [CW-1:0]         cfg_ext;

  sxfb_fade_unit #(
    .ADDR_W    (FA_W),
    .FADE_BITS (FADE_BITS)
  ) u_fade (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (fa_rd_en),
    .rd_addr  (fa_rd_addr),
    .rd_level (fa_rd_level),
    .wr_en    (fa_wr_en),
    .wr_addr  (fa_wr_addr),
    .wr_level (fa_wr_level),
    .busy     (fa_busy)
  );

  assign in_stall  = (state_r != ST_IDLE) || fa_busy;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign old_row  = frame_rdv_r ? frame_rd_r : '0;
  assign row_sum  = 9'(in_data.y_coord) + 9'(in_data.sprite_row_index);
  assign cfg_ext  = CW'(cfg_wr_data);
  assign pix_on   = row_sr_r[W-1];
  assign last_pix = (p1_col_r == COL_W'(W - 1));
  assign p1_adv   = p1_valid_r && out_free;
  assign issue    = (state_r == ST_SCAN) && (rd_cnt_r < (COL_W + 1)'(W)) &&
                    (!p1_valid_r || p1_adv);

  // x modulo the width by restoring steps; x stays below 64 times the width.
  always_comb begin
    x_mod = 12'(in_data.x_coord);
    for (int k = 5; k >= 0; k--) begin
      if (x_mod >= 12'(W << k)) begin
        x_mod = x_mod - 12'(W << k);
      end
    end
  end

  // The sprite's leftmost pixel lands on column x mod W; bits past the edge fall off.
  assign spr      = SC'(in_data.sprite_bits);
  assign spr_wide = {spr, {W{1'b0}}} >> COL_W'(x_mod);

  always_comb begin
    state_nxt       = state_r;
    fade_frames_nxt = fade_frames_r;
    coll_nxt        = coll_r;
    frame_valid_nxt = frame_valid_r;
    frame_rdv_nxt   = frame_rdv_r;
    mask_nxt        = mask_r;
    row_nxt         = row_r;
    row_ok_nxt      = row_ok_r;
    row_sr_nxt      = row_sr_r;
    rd_cnt_nxt      = rd_cnt_r;
    p1_valid_nxt    = p1_valid_r;
    p1_col_nxt      = p1_col_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && out_stall;
    fr_re           = 1'b0;
    fr_raddr        = row_sum[ROW_W-1:0];
    fr_we           = 1'b0;
    fr_wdata        = old_row ^ mask_r;
    fa_rd_en        = issue;
    fa_rd_addr      = {row_r, rd_cnt_r[COL_W-1:0]};
    fa_wr_en        = 1'b0;
    fa_wr_addr      = {row_r, p1_col_r};
    fa_wr_level     = '0;

    if (cfg_wr_en) begin
      fade_frames_nxt = (cfg_ext > CW'(FADE_CAP)) ? FADE_BITS'(FADE_CAP)
                                                   : FADE_BITS'(cfg_ext);
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.command)
            CMD_DRAW: begin
              if (in_data.first_row) begin
                coll_nxt = 1'b0;
              end
              row_ok_nxt    = (row_sum < 9'(H));
              row_nxt       = row_sum[ROW_W-1:0];
              mask_nxt      = spr_wide[W+SC-1:SC];
              fr_re         = 1'b1;
              frame_rdv_nxt = frame_valid_r[row_sum[ROW_W-1:0]];
              state_nxt     = ST_DRAW;
            end
            CMD_CLEAR: begin
              frame_valid_nxt = '0;
            end
            CMD_SCAN: begin
              if (7'(in_data.scan_line) < 7'(H)) begin
                row_nxt       = ROW_W'(in_data.scan_line);
                fr_raddr      = ROW_W'(in_data.scan_line);
                fr_re         = 1'b1;
                frame_rdv_nxt = frame_valid_r[ROW_W'(in_data.scan_line)];
                state_nxt     = ST_SCAN_LD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAW: begin
        if (out_free) begin
          if (row_ok_r) begin
            fr_we = 1'b1;
            frame_valid_nxt[row_r] = 1'b1;
            coll_nxt = coll_r | (|(old_row & mask_r));
          end
          out_nxt              = '0;
          out_nxt.collision    = row_ok_r ? (coll_r | (|(old_row & mask_r))) : coll_r;
          out_nxt.last         = 1'b1;
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      ST_SCAN_LD: begin
        row_sr_nxt   = old_row;
        rd_cnt_nxt   = '0;
        p1_valid_nxt = 1'b0;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        if (p1_adv) begin
          p1_valid_nxt = 1'b0;
          row_sr_nxt   = row_sr_r << 1;
          fa_wr_en     = 1'b1;
          if (pix_on) begin
            fa_wr_level = fade_frames_r + 1'b1;
          end else if (fa_rd_level != '0) begin
            fa_wr_level = fa_rd_level - 1'b1;
          end
          out_nxt.collision    = 1'b0;
          out_nxt.pixel_column = 6'(p1_col_r);
          out_nxt.pixel_on     = pix_on;
          out_nxt.fade_level   = 4'(fa_wr_level);
          out_nxt.last         = last_pix;
          out_valid_nxt        = 1'b1;
          if (last_pix) begin
            state_nxt = ST_IDLE;
          end
        end
        if (issue) begin
          p1_valid_nxt = 1'b1;
          p1_col_nxt   = rd_cnt_r[COL_W-1:0];
          rd_cnt_nxt   = rd_cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      fade_frames_r <= '0;
      coll_r        <= 1'b0;
      frame_valid_r <= '0;
      frame_rdv_r   <= 1'b0;
      row_ok_r      <= 1'b0;
      rd_cnt_r      <= '0;
      p1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      fade_frames_r <= fade_frames_nxt;
      coll_r        <= coll_nxt;
      frame_valid_r <= frame_valid_nxt;
      frame_rdv_r   <= frame_rdv_nxt;
      row_ok_r      <= row_ok_nxt;
      rd_cnt_r      <= rd_cnt_nxt;
      p1_valid_r    <= p1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    mask_r   <= mask_nxt;
    row_r    <= row_nxt;
    row_sr_r <= row_sr_nxt;
    p1_col_r <= p1_col_nxt;
    out_r    <= out_nxt;
  end

  // Frame rows live in a memory; a row reads as zero until written after a clear.
  always_ff @(posedge clk) begin
    if (fr_we) begin
      frame_mem[row_r] <= fr_wdata;
    end
    if (fr_re) begin
      frame_rd_r <= frame_mem[fr_raddr];
    end
  end

endmodule

/* tb/sv/sprite_xor_frame_buffer_with_fade_tb.sv */
`timescale 1ns / 1ps

module sprite_xor_frame_buffer_with_fade_tb;
  import sxfb_pkg::*;

  localparam int W = SXFB_DISPLAY_WIDTH;
  localparam int H = SXFB_DISPLAY_HEIGHT;
  localparam int SPRITE_W = SXFB_SPRITE_COLS;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [3:0] FADE_CAP = 4'd14;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_OFF_CYCLES = 300;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  sxfb_in_t   in_data;
  logic       out_valid;
  logic       out_stall;
  sxfb_out_t  out_data;
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;

  sprite_xor_frame_buffer_with_fade dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Shadow copy of the display state, updated as each request is accepted.
  logic [W-1:0] frame_rows [H];
  logic [3:0]   fade_levels [H][W];
  logic         collision_bit;
  logic [3:0]   fade_len;
  sxfb_out_t    awaited_out [$];

  int send_idle_pct;
  int stall_pct;
  int hold_cycles;
  int errors;
  int draws_sent;
  int scans_sent;
  int clears_sent;
  int results_seen;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch in %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic sxfb_in_t make_req(input logic [1:0] cmd, input int x, input int y,
                                        input int ri, input int bits, input int first,
                                        input int line);
    sxfb_in_t r;
    r.command          = cmd;
    r.x_coord          = 8'(x);
    r.y_coord          = 8'(y);
    r.sprite_row_index = 4'(ri);
    r.sprite_bits      = 8'(bits);
    r.first_row        = 1'(first);
    r.scan_line        = 5'(line);
    return r;
  endfunction

  task automatic update_frame_and_fade(input sxfb_in_t req);
    sxfb_out_t res;
    int row;
    int left;
    int col;
    int c;
    int line;
    res = '0;
    case (req.command)
      CMD_DRAW: begin
        row  = req.y_coord + req.sprite_row_index;
        left = req.x_coord % W;
        if (req.first_row) collision_bit = 1'b0;
        if (row < H) begin
          for (c = 0; c < SPRITE_W; c++) begin
            col = left + c;
            if (req.sprite_bits[SPRITE_W-1-c] && col < W) begin
              if (frame_rows[row][W-1-col]) collision_bit = 1'b1;
              frame_rows[row][W-1-col] = ~frame_rows[row][W-1-col];
            end
          end
        end
        res.collision = collision_bit;
        res.last      = 1'b1;
        awaited_out.push_back(res);
      end
      CMD_CLEAR: begin
        for (row = 0; row < H; row++) frame_rows[row] = '0;
      end
      CMD_SCAN: begin
        line = req.scan_line;
        if (line < H) begin
          for (col = 0; col < W; col++) begin
            res.pixel_on = frame_rows[line][W-1-col];
            if (res.pixel_on) fade_levels[line][col] = fade_len + 4'd1;
            else if (fade_levels[line][col] != 4'd0)
              fade_levels[line][col] = fade_levels[line][col] - 4'd1;
            res.pixel_column = 6'(col);
            res.fade_level   = fade_levels[line][col];
            res.last         = (col == W - 1);
            awaited_out.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offers one request after a random gap and returns once it is accepted.
  task automatic send_cmd(input sxfb_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    update_frame_and_fade(req);
    case (req.command)
      CMD_DRAW:  draws_sent++;
      CMD_SCAN:  scans_sent++;
      CMD_CLEAR: clears_sent++;
      default: ;
    endcase
  endtask

  // A clear returns nothing, so settling goes on past the last result.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fade(input logic [3:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fade_len = (value > FADE_CAP) ? FADE_CAP : value;
    @(posedge clk);
  endtask

  initial begin : result_checker
    sxfb_out_t exp;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        if (awaited_out.size() == 0) begin
          report("unexpected result", int'(out_data), 0);
        end else begin
          exp = awaited_out.pop_front();
          if (out_data.collision !== exp.collision)
            report("collision", out_data.collision, exp.collision);
          if (out_data.pixel_column !== exp.pixel_column)
            report("pixel_column", out_data.pixel_column, exp.pixel_column);
          if (out_data.pixel_on !== exp.pixel_on)
            report("pixel_on", out_data.pixel_on, exp.pixel_on);
          if (out_data.fade_level !== exp.fade_level)
            report("fade_level", out_data.fade_level, exp.fade_level);
          if (out_data.last !== exp.last)
            report("last", out_data.last, exp.last);
        end
      end
    end
  end

  // The receiver stall; a long hold-off is counted here ahead of the random mix.
  initial begin : stall_driver
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("== FAIL ==");
    $finish;
  end

  task automatic test_directed();
    send_idle_pct = 33;
    stall_pct     = 33;
    write_fade(4'd3);
    send_cmd(make_req(CMD_DRAW, 0, 0, 0, 8'hFF, 1, 0));
    // Same sprite again turns every pixel off, which sets the collision flag.
    send_cmd(make_req(CMD_DRAW, 0, 0, 0, 8'hFF, 0, 31));
    send_cmd(make_req(CMD_DRAW, 0, 0, 0, 8'h81, 1, 0));
    send_cmd(make_req(CMD_DRAW, 60, 5, 0, 8'hFF, 1, 31));
    send_cmd(make_req(CMD_DRAW, 255, 255, 15, 8'hFF, 1, 0));
    send_cmd(make_req(CMD_DRAW, 128, 16, 15, 8'hAA, 0, 31));
    send_cmd(make_req(CMD_DRAW, 63, 17, 15, 8'hFF, 0, 0));
    send_cmd(make_req(CMD_DRAW, 7, 31, 0, 8'h00, 0, 31));
    send_cmd(make_req(CMD_DRAW, 200, 3, 7, 8'h5A, 1, 31));
    send_cmd(make_req(CMD_UNUSED, 255, 255, 15, 8'hFF, 1, 31));
    send_cmd(make_req(CMD_SCAN, 0, 0, 0, 0, 0, 0));
    send_cmd(make_req(CMD_SCAN, 255, 255, 15, 8'hFF, 1, 5));
    send_cmd(make_req(CMD_SCAN, 0, 0, 0, 0, 0, 31));
    send_cmd(make_req(CMD_SCAN, 0, 0, 0, 0, 0, 10));
    send_cmd(make_req(CMD_CLEAR, 255, 255, 15, 8'hFF, 1, 31));
    // With the buffer cleared the levels of row zero fade out step by step.
    repeat (4) send_cmd(make_req(CMD_SCAN, 0, 0, 0, 0, 0, 0));
    send_cmd(make_req(CMD_SCAN, 0, 0, 0, 0, 0, 5));
    send_cmd(make_req(CMD_DRAW, 1, 1, 0, 8'hFF, 1, 0));
    send_cmd(make_req(CMD_SCAN, 0, 0, 0, 0, 0, 1));
    settle();
  endtask

  task automatic test_fade_settings();
    logic [3:0] settings [4];
    int i;
    settings = '{4'd0, 4'd15, 4'd14, 4'd1};
    for (i = 0; i < 4; i++) begin
      write_fade(settings[i]);
      send_cmd(make_req(CMD_DRAW, 20, 20, 0, $urandom_range(1, 255), 1, 0));
      send_cmd(make_req(CMD_SCAN, 0, 0, 0, 0, 0, 20));
      send_cmd(make_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
      repeat (2) send_cmd(make_req(CMD_SCAN, 0, 0, 0, 0, 0, 20));
      settle();
    end
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int count);
    int n;
    int pick;
    int rows;
    int i;
    int x;
    int y;
    int first;
    int ri;
    send_idle_pct = idle;
    stall_pct     = stall;
    write_fade(4'($urandom_range(15)));
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // A whole sprite: rows share x and y; mostly only the first clears collision.
        rows = $urandom_range(1, 15);
        x = $urandom_range(255);
        y = ($urandom_range(99) < 85) ? $urandom_range(H - 1) : $urandom_range(255);
        for (i = 0; i < rows; i++) begin
          first = (i == 0);
          ri    = i;
          if ($urandom_range(99) < 8) begin
            first = $urandom_range(1);
            ri    = $urandom_range(15);
          end
          send_cmd(make_req(CMD_DRAW, x, y, ri, $urandom_range(255), first,
                            $urandom_range(31)));
        end
        n += rows;
      end else if (pick < 80) begin
        send_cmd(make_req(CMD_SCAN, $urandom_range(255), $urandom_range(255),
                          $urandom_range(15), $urandom_range(255), $urandom_range(1),
                          $urandom_range(31)));
        n++;
      end else if (pick < 87) begin
        send_cmd(make_req(CMD_CLEAR, $urandom_range(255), $urandom_range(255),
                          $urandom_range(15), $urandom_range(255), $urandom_range(1),
                          $urandom_range(31)));
        n++;
      end else if (pick < 92) begin
        send_cmd(make_req(CMD_UNUSED, $urandom_range(255), $urandom_range(255),
                          $urandom_range(15), $urandom_range(255), $urandom_range(1),
                          $urandom_range(31)));
      end else begin
        send_cmd(make_req(CMD_DRAW, $urandom_range(255), $urandom_range(255),
                          $urandom_range(15), $urandom_range(255), $urandom_range(1),
                          $urandom_range(31)));
        n++;
      end
    end
    settle();
  endtask

  // The result side holds off for a long stretch while requests keep coming.
  task automatic test_output_hold_off();
    int i;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = HOLD_OFF_CYCLES;
    for (i = 0; i < 4; i++) begin
      send_cmd(make_req(CMD_DRAW, $urandom_range(255), $urandom_range(H - 1), 0,
                        $urandom_range(255), 1, 0));
      send_cmd(make_req(CMD_SCAN, 0, 0, 0, 0, 0, $urandom_range(31)));
    end
    settle();
  endtask

  initial begin : main_seq
    int r;
    int c;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    errors        = 0;
    draws_sent    = 0;
    scans_sent    = 0;
    clears_sent   = 0;
    results_seen  = 0;
    collision_bit = 1'b0;
    fade_len      = '0;
    for (r = 0; r < H; r++) begin
      frame_rows[r] = '0;
      for (c = 0; c < W; c++) fade_levels[r][c] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fade_settings();
    test_random_phase(0, 0, 50);
    test_random_phase(63, 0, 50);
    test_random_phase(0, 63, 50);
    test_random_phase(33, 33, 50);
    test_output_hold_off();

    $display("run covered %0d draw, %0d scan and %0d clear requests, %0d results checked",
             draws_sent, scans_sent, clears_sent, results_seen);
    $display("fade lengths from zero to the cap, four idle/stall mixes, one long hold-off");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
